// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned SideW  = 17;
	localparam int unsigned AreaW  = 34;
	localparam int unsigned ThrW   = 9;
	localparam int unsigned SlotW  = 8;

	localparam logic [2:0] RegThreshold = 3'd0;
	localparam logic [2:0] RegKeepLimit = 3'd1;

	typedef struct packed {
		logic [CoordW-1:0] x0;
		logic [CoordW-1:0] y0;
		logic [CoordW-1:0] x1;
		logic [CoordW-1:0] y1;
	} box_t;

	// one classified proposal handed from front to back
	typedef struct packed {
		logic clear;
		logic cand;
		box_t box;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AREA,
		ST_READ,
		ST_CMP,
		ST_DONE
	} bk_state_t;

	// side length: far - near + 16, clamped at zero
	function automatic logic [SideW-1:0] side_len(input logic [CoordW-1:0] lo,
		input logic [CoordW-1:0] hi);
		logic [SideW:0] d;
		begin
			d = {2'b00, hi} + (SideW+1)'(16) - {2'b00, lo};
			side_len = d[SideW] ? '0 : d[SideW-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/gbn_ram.sv =====
module gbn_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/gbn_front.sv =====
module gbn_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       first_of_set,
	input  logic [15:0]                left_edge,
	input  logic [15:0]                top_edge,
	input  logic [15:0]                right_edge,
	input  logic [15:0]                bottom_edge,
	input  logic signed [15:0]         score,
	output logic                       full,
	output logic                       job_valid,
	output gbn_pkg::job_t              job,
	input  logic                       job_pop
);

	// two-entry queue of classified beats
	gbn_pkg::job_t q_q [2];
	logic [1:0]    cnt_q;
	logic          rd_q, wr_q;
	logic          take;
	gbn_pkg::job_t in_job;

	// classify: candidate only for positive score
	always_comb begin
		in_job.clear = first_of_set;
		in_job.cand  = (score > 16'sd0);
		in_job.box   = '{left_edge, top_edge, right_edge, bottom_edge};
	end

	assign take      = start && !full;
	assign full      = cnt_q[1];
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (take) begin
			q_q[wr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (take) wr_q <= ~wr_q;
			if (job_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, job_pop};
		end
	end

	ap_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(take && full))
		else $error("queue overrun");
	ap_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_pop && !job_valid))
		else $error("queue underrun");
	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ===== hw/rtl/gbn_back.sv =====
module gbn_back #(
	parameter int unsigned MAX_KEPT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [8:0]         thr,
	input  logic [8:0]         lim,
	input  logic               job_valid,
	input  gbn_pkg::job_t      job,
	output logic               job_pop,
	output logic               idle,
	output logic               done,
	output gbn_pkg::box_t      kept_box,
	output logic [7:0]         kept_slot
);

	localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int unsigned CW = $clog2(MAX_KEPT + 1);

	gbn_pkg::bk_state_t st_q, st_d;
	gbn_pkg::box_t      nb_q;
	logic [CW-1:0]      cnt_q, idx_q;
	logic [gbn_pkg::AreaW-1:0] na_q;
	logic               hit_q;
	logic               cand_q;
	logic [63:0]        rdata;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [CW-1:0]      lim_e, cnt_eff;

	// effective limit clamped at MAX_KEPT
	always_comb begin
		if ({23'd0, lim} > MAX_KEPT) lim_e = CW'(MAX_KEPT);
		else lim_e = CW'(lim);
	end
	assign cnt_eff = job.clear ? '0 : cnt_q;

	// overlap stage one: intersection and kept area products
	gbn_pkg::box_t kb;
	logic [gbn_pkg::SideW-1:0] iw, ih, kw, kh;
	logic [gbn_pkg::AreaW-1:0] inter_s1, ka_s1;
	logic cmp_s1;
	assign kb = rdata;
	always_comb begin
		iw = gbn_pkg::side_len((nb_q.x0 > kb.x0) ? nb_q.x0 : kb.x0,
			(nb_q.x1 < kb.x1) ? nb_q.x1 : kb.x1);
		ih = gbn_pkg::side_len((nb_q.y0 > kb.y0) ? nb_q.y0 : kb.y0,
			(nb_q.y1 < kb.y1) ? nb_q.y1 : kb.y1);
		kw = gbn_pkg::side_len(kb.x0, kb.x1);
		kh = gbn_pkg::side_len(kb.y0, kb.y1);
	end

	always_ff @(posedge clk) begin
		inter_s1 <= iw * ih;
		ka_s1    <= kw * kh;
	end

	// overlap stage two: inter*256 > thr*union
	logic [gbn_pkg::AreaW:0]   uni;
	logic [gbn_pkg::AreaW+9:0] lhs, rhs;
	assign uni = {1'b0, ka_s1} + {1'b0, na_q} - {1'b0, inter_s1};
	assign lhs = {2'b0, inter_s1, 8'd0};
	assign rhs = (gbn_pkg::AreaW+10)'(uni * thr);

	// pipeline: read issued, data, products; cmp_s1 marks valid products
	logic rdv_s1;
	logic [CW-1:0] left_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			gbn_pkg::ST_IDLE: if (job_valid) st_d = gbn_pkg::ST_AREA;
			gbn_pkg::ST_AREA:
				if (cnt_q >= lim_e || !cand_q) st_d = gbn_pkg::ST_IDLE;
				else if (cnt_q == '0) st_d = gbn_pkg::ST_DONE;
				else st_d = gbn_pkg::ST_READ;
			gbn_pkg::ST_READ: if (idx_q == cnt_q - CW'(1)) st_d = gbn_pkg::ST_CMP;
			gbn_pkg::ST_CMP:
				if (hit_q || (cmp_s1 && lhs > rhs)) st_d = gbn_pkg::ST_IDLE;
				else if (left_q == '0) st_d = gbn_pkg::ST_DONE;
			gbn_pkg::ST_DONE: st_d = gbn_pkg::ST_IDLE;
			default: st_d = gbn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (st_q == gbn_pkg::ST_IDLE) && job_valid;
		idle    = (st_q == gbn_pkg::ST_IDLE);
		done    = (st_q == gbn_pkg::ST_DONE);
		we      = done;
		raddr   = AW'(idx_q);
	end

	assign kept_box  = nb_q;
	assign kept_slot = 8'(cnt_q);

	gbn_ram #(.WIDTH(64), .DEPTH(MAX_KEPT)) u_ram (
		.clk(clk), .we(we), .waddr(AW'(cnt_q)), .wdata(nb_q),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= gbn_pkg::ST_IDLE;
			cnt_q  <= '0;
			idx_q  <= '0;
			rdv_s1 <= 1'b0;
			cmp_s1 <= 1'b0;
			hit_q  <= 1'b0;
			left_q <= '0;
			cand_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cmp_s1 <= rdv_s1;
			rdv_s1 <= (st_q == gbn_pkg::ST_READ);
			if (job_pop) begin
				cnt_q  <= cnt_eff;
				cand_q <= job.cand;
				idx_q  <= '0;
			end
			// a compare still in the pipe at a pop belongs to the previous beat
			if (job_pop) hit_q <= 1'b0;
			else if (cmp_s1 && lhs > rhs) hit_q <= 1'b1;
			if (st_q == gbn_pkg::ST_AREA) left_q <= cnt_q;
			else if (cmp_s1) left_q <= left_q - CW'(1);
			if (st_q == gbn_pkg::ST_READ && st_d == gbn_pkg::ST_READ) idx_q <= idx_q + CW'(1);
			if (done) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) nb_q <= job.box;
		if (st_q == gbn_pkg::ST_AREA)
			na_q <= gbn_pkg::side_len(nb_q.x0, nb_q.x1) * gbn_pkg::side_len(nb_q.y0, nb_q.y1);
	end

	ap_keep_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> cnt_q < lim_e)
		else $error("kept beyond limit");
	ap_keep_cand: assert property (@(posedge clk) disable iff (!arst_n) done |-> cand_q)
		else $error("non-candidate kept");
	ap_keep_clear: assert property (@(posedge clk) disable iff (!arst_n) done |-> !hit_q)
		else $error("suppressed box kept");

endmodule

// ===== hw/rtl/greedy_box_nms.sv =====
// Greedy box suppression. A proposal is taken when start is high and busy low.
// Each proposal holds the back end while it is compared with the K kept boxes
// of its set (up to MAX_KEPT), read from memory one entry a cycle; an empty set
// goes straight to the result and a skipped proposal frees it without reads. A
// two-beat queue lets up to two proposals wait. An accepted box appears for one
// cycle with done high and cannot be stalled.
module greedy_box_nms #(
	parameter int unsigned MAX_KEPT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               first_of_set,
	input  logic [15:0]        left_edge,
	input  logic [15:0]        top_edge,
	input  logic [15:0]        right_edge,
	input  logic [15:0]        bottom_edge,
	input  logic signed [15:0] score,
	output logic               done,
	output logic [15:0]        kept_left,
	output logic [15:0]        kept_top,
	output logic [15:0]        kept_right,
	output logic [15:0]        kept_bottom,
	output logic [7:0]         kept_slot
);

	logic [8:0] thr_q, lim_q;
	logic full, jv, pop, idle, dn;
	gbn_pkg::job_t job;
	gbn_pkg::box_t kb;
	logic [7:0] slot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 9'd179;
			lim_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index == gbn_pkg::RegThreshold) thr_q <= cfg_data;
			if (cfg_index == gbn_pkg::RegKeepLimit) lim_q <= cfg_data;
		end
	end

	assign busy = full;

	gbn_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.first_of_set(first_of_set), .left_edge(left_edge), .top_edge(top_edge),
		.right_edge(right_edge), .bottom_edge(bottom_edge), .score(score),
		.full(full), .job_valid(jv), .job(job), .job_pop(pop)
	);

	gbn_back #(.MAX_KEPT(MAX_KEPT)) u_back (
		.clk(clk), .arst_n(arst_n), .thr(thr_q), .lim(lim_q),
		.job_valid(jv), .job(job), .job_pop(pop), .idle(idle), .done(dn),
		.kept_box(kb), .kept_slot(slot)
	);

	// result beat
	assign done        = dn;
	assign kept_left   = kb.x0;
	assign kept_top    = kb.y0;
	assign kept_right  = kb.x1;
	assign kept_bottom = kb.y1;
	assign kept_slot   = slot;

	ap_done_busy_back: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && idle))
		else $error("result while idle");
	ap_pop_idle: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !idle))
		else $error("pop while working");
	ap_busy_queue: assert property (@(posedge clk) disable iff (!arst_n) busy |-> jv)
		else $error("busy without queue");

endmodule
